// ----- rtl/core/crfv_pkg.sv -----
// Shared constants, types and the CRC byte step for the framed record checker.
package crfv_pkg;

   localparam int MAX_RECORD_BYTES = 4096;
   localparam int HEADER_BYTES     = 20;
   localparam int TRAILER_BYTES    = 4;
   localparam int LEN_MAX          = MAX_RECORD_BYTES - HEADER_BYTES - TRAILER_BYTES;
   localparam int POS_W            = $clog2(MAX_RECORD_BYTES + 1);

   localparam logic [31:0] CRC_POLY       = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT       = 32'hFFFFFFFF;
   localparam logic [7:0]  RECORD_VERSION = 8'd1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_MAGIC = 1'b0;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_SHORT    = 3'd1,
      ST_MAGIC    = 3'd2,
      ST_VERSION  = 3'd3,
      ST_OVERRUN  = 3'd4,
      ST_CRC      = 3'd5
   } status_type;

   typedef enum logic [1:0] {
      HE_NONE    = 2'd0,
      HE_MAGIC   = 2'd1,
      HE_VERSION = 2'd2
   } herr_type;

   // one classified byte on its way from the front to the back
   typedef struct packed {
      logic [7:0]  data_byte;
      logic        do_crc;
      logic        do_gen;
      logic        do_trailer;
      logic        crc_latch;
      logic        last;
      status_type  pre_status;   // ST_OK here means the CRC still decides
      logic [11:0] payload_length;
   } entry_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
      end
      return c;
   endfunction

endpackage

// ----- rtl/core/crfv_req_if.sv -----
// Request channel: one record byte per transfer.
interface crfv_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- rtl/core/crfv_rsp_if.sv -----
// Response channel: one check result per record.
interface crfv_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  record_status;
   logic [63:0] generation;
   logic [11:0] payload_length;

   modport source (output valid, output record_status, output generation,
                   output payload_length, input ready);
   modport sink   (input valid, input record_status, input generation,
                   input payload_length, output ready);
endinterface

// ----- rtl/core/crfv_front.sv -----
// Front end: byte counting, header checks, length capture and byte classification.
module crfv_front (
   input  logic                clock,
   input  logic                reset,
   crfv_req_if.sink            req_chan,
   input  logic                queue_full,
   input  logic [31:0]         magic_word,
   output logic                push,
   output crfv_pkg::entry_type push_entry
);
   import crfv_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [31:0]      length_ff, length_in;
   herr_type         herr_ff, herr_in;

   logic [POS_W-1:0] p;
   logic [POS_W-1:0] len_p;
   logic [POS_W-1:0] rlen;
   logic             len_ok;
   logic [7:0]       b;
   logic [7:0]       want;
   status_type       status;

   assign req_chan.ready = !queue_full;
   assign push           = req_chan.valid && !queue_full;
   assign p              = pos_ff;
   assign b              = req_chan.data_byte;

   always_comb begin
      unique case (p[1:0])
         2'd0:    want = magic_word[31:24];
         2'd1:    want = magic_word[23:16];
         2'd2:    want = magic_word[15:8];
         default: want = magic_word[7:0];
      endcase
   end

   always_comb begin
      herr_in   = herr_ff;
      length_in = length_ff;
      if (p < POS_W'(4)) begin
         if (b != want && herr_ff == HE_NONE) herr_in = HE_MAGIC;
      end else if (p == POS_W'(4)) begin
         if (b != RECORD_VERSION && herr_ff == HE_NONE) herr_in = HE_VERSION;
      end else if (p < POS_W'(8)) begin
         if (b != 8'd0 && herr_ff == HE_NONE) herr_in = HE_VERSION;
      end else if (p >= POS_W'(16) && p < POS_W'(HEADER_BYTES)) begin
         length_in = {length_ff[23:0], b};
      end

      pos_in = (pos_ff < POS_W'(MAX_RECORD_BYTES)) ? pos_ff + POS_W'(1) : pos_ff;
      rlen   = pos_in;
      len_ok = (length_in <= 32'(LEN_MAX));
      len_p  = len_ok ? length_in[POS_W-1:0] : '0;

      push_entry.data_byte  = b;
      push_entry.last       = req_chan.last_byte;
      push_entry.do_gen     = (p >= POS_W'(8)) && (p < POS_W'(16));
      push_entry.do_crc     = 1'b0;
      push_entry.do_trailer = 1'b0;
      if (p < POS_W'(HEADER_BYTES)) begin
         push_entry.do_crc = 1'b1;
      end else if (len_ok) begin
         if (p < POS_W'(HEADER_BYTES) + len_p)
            push_entry.do_crc = 1'b1;
         else if (p < POS_W'(HEADER_BYTES + TRAILER_BYTES) + len_p)
            push_entry.do_trailer = 1'b1;
      end
      push_entry.crc_latch = len_ok && (p >= POS_W'(HEADER_BYTES - 1))
                             && (p == POS_W'(HEADER_BYTES - 1) + len_p);

      priority if (rlen < POS_W'(HEADER_BYTES + TRAILER_BYTES))
         status = ST_SHORT;
      else if (herr_in == HE_MAGIC)
         status = ST_MAGIC;
      else if (herr_in != HE_NONE)
         status = ST_VERSION;
      else if (!len_ok || len_p > rlen - POS_W'(HEADER_BYTES + TRAILER_BYTES))
         status = ST_OVERRUN;
      else
         status = ST_OK;
      push_entry.pre_status     = status;
      push_entry.payload_length = (status == ST_OK) ? length_in[11:0] : 12'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         length_ff <= '0;
         herr_ff   <= HE_NONE;
      end else if (push) begin
         if (req_chan.last_byte) begin
            pos_ff    <= '0;
            length_ff <= '0;
            herr_ff   <= HE_NONE;
         end else begin
            pos_ff    <= pos_in;
            length_ff <= length_in;
            herr_ff   <= herr_in;
         end
      end
   end

endmodule

// ----- rtl/core/crfv_queue.sv -----
// Small FIFO of classified bytes between front and back.
module crfv_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  crfv_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output crfv_pkg::entry_type head
);
   import crfv_pkg::*;

   entry_type         slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wptr_ff, wptr_in;
   logic [QPTR_W-1:0] rptr_ff, rptr_in;
   logic [QPTR_W:0]   count_ff, count_in;

   assign full       = (count_ff == (QPTR_W + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = push ? wptr_ff + QPTR_W'(1) : wptr_ff;
      rptr_in  = pop  ? rptr_ff + QPTR_W'(1) : rptr_ff;
      count_in = count_ff + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (push) slot_ff[wptr_ff] <= push_entry;
   end

endmodule

// ----- rtl/core/crfv_back.sv -----
// Back end: CRC, generation and trailer registers, final compare and result register.
module crfv_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  crfv_pkg::entry_type head,
   output logic                pop,
   crfv_rsp_if.source          rsp_chan
);
   import crfv_pkg::*;

   logic [31:0] crc_ff, crc_in;
   logic [63:0] gen_ff, gen_in;
   logic [31:0] trailer_ff, trailer_in;
   logic [31:0] latched_ff, latched_in;

   logic        out_valid_ff, out_valid_in;
   status_type  out_status_ff, status;
   logic [63:0] out_gen_ff;
   logic [11:0] out_len_ff;

   // non-final bytes never need the result register
   assign pop = head_valid && (!head.last || !out_valid_ff || rsp_chan.ready);

   always_comb begin
      crc_in     = head.do_crc ? crc_byte(crc_ff, head.data_byte) : crc_ff;
      gen_in     = head.do_gen ? {gen_ff[55:0], head.data_byte} : gen_ff;
      trailer_in = head.do_trailer ? {trailer_ff[23:0], head.data_byte} : trailer_ff;
      latched_in = head.crc_latch ? ~crc_in : latched_ff;
      if (head.pre_status != ST_OK)
         status = head.pre_status;
      else if (trailer_in != latched_in)
         status = ST_CRC;
      else
         status = ST_OK;
      if (pop && head.last)
         out_valid_in = 1'b1;
      else if (rsp_chan.ready)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= CRC_INIT;
         gen_ff       <= '0;
         trailer_ff   <= '0;
         latched_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            if (head.last) begin
               crc_ff     <= CRC_INIT;
               gen_ff     <= '0;
               trailer_ff <= '0;
               latched_ff <= '0;
            end else begin
               crc_ff     <= crc_in;
               gen_ff     <= gen_in;
               trailer_ff <= trailer_in;
               latched_ff <= latched_in;
            end
         end
      end
      if (pop && head.last) begin
         out_status_ff <= status;
         out_gen_ff    <= (status == ST_SHORT || status == ST_MAGIC
                           || status == ST_VERSION) ? 64'd0 : gen_in;
         out_len_ff    <= (status == ST_OK) ? head.payload_length : 12'd0;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.record_status  = out_status_ff;
   assign rsp_chan.generation     = out_gen_ff;
   assign rsp_chan.payload_length = out_len_ff;

endmodule

// ----- rtl/core/crc32_record_frame_validator_core.sv -----
// Top level of the framed record checker: register port, front, queue and back.
//
// Requests carry one record byte each (data_byte) with last_byte set on the
// final byte. The header holds the magic (compared against magic_word),
// version 1, three zero bytes, a big-endian generation and a 32-bit payload
// length; a big-endian reflected CRC-32 over header and payload follows the
// payload. Bytes past the trailer are counted but otherwise ignored.
// One response per record is produced for the last byte: record_status,
// generation and payload_length. Errors rank short, magic, version or
// reserved, length overrun, CRC mismatch.
// Throughput: one byte per cycle while the queue is not full, set by the
// byte-wide CRC update in the back. The last byte is queued; when it is at the
// head and the response register is free, its result moves into that register.
// When the response is stalled the front keeps taking bytes until the queue
// fills. magic_word sits at byte address 0 and resets to zero; write it
// only while no record is in flight. Synchronous reset clears all record state.
module crc32_record_frame_validator_core (
   input  logic                                clock,
   input  logic                                reset,
   crfv_req_if.sink                            req_chan,
   crfv_rsp_if.source                          rsp_chan,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [crfv_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [crfv_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [crfv_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);
   import crfv_pkg::*;

   logic [31:0] magic_ff;
   logic        push;
   entry_type   push_entry;
   logic        queue_full;
   logic        pop;
   logic        head_valid;
   entry_type   head;
   logic        csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MAGIC) ? magic_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_ff <= '0;
      end else if (csr_write && csr_paddr[2] == CSR_IDX_MAGIC) begin
         magic_ff <= csr_pwdata;
      end
   end

   crfv_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .queue_full (queue_full),
      .magic_word (magic_ff),
      .push       (push),
      .push_entry (push_entry)
   );

   crfv_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   crfv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

// ----- sim/tb_crc32_record_frame_validator_core.sv -----
// Self-checking testbench for the framed record checker: random and directed records.
module tb_crc32_record_frame_validator_core;
   timeunit 1ns;
   timeprecision 1ps;

   import crfv_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1_000_000;
   localparam logic [CSR_ADDR_W-1:0] MAGIC_ADDR = CSR_ADDR_W'(4 * int'(CSR_IDX_MAGIC));

   typedef struct packed {
      status_type  status;
      logic [63:0] generation;
      logic [11:0] payload_length;
   } record_check_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   crfv_req_if req_bus ();
   crfv_rsp_if rsp_bus ();

   crc32_record_frame_validator_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // checker's own copy of the block state
   logic [31:0]      magic_model;
   int unsigned      frame_pos;
   logic [31:0]      crc_run;
   logic [63:0]      gen_acc;
   logic [31:0]      len_acc;
   logic [31:0]      trailer_acc;
   logic [31:0]      crc_seal;
   herr_type         herr;
   record_check_type pending_checks[$];

   int unsigned     error_count;
   int unsigned     bytes_sent;
   logic            steady_send;
   int unsigned     ready_hold;
   int unsigned     ready_sel;
   logic [31:0]     cur_magic;
   logic [7:0]      frame_buf[$];

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic logic [31:0] crc32_update(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) c = (c >> 1) ^ 32'hEDB88320;
         else c = c >> 1;
      end
      return c;
   endfunction

   function automatic void clear_frame();
      frame_pos   = 0;
      crc_run     = 32'hFFFFFFFF;
      gen_acc     = '0;
      len_acc     = '0;
      trailer_acc = '0;
      crc_seal    = '0;
      herr        = HE_NONE;
   endfunction

   function automatic void predict_byte(input logic [7:0] b, input logic l);
      longint unsigned  p;
      longint unsigned  len;
      longint unsigned  rlen;
      logic [7:0]       want;
      record_check_type r;
      p = frame_pos;
      if (p < 4) begin
         want = 8'(magic_model >> (8 * (3 - p)));
         if (b != want && herr == HE_NONE) herr = HE_MAGIC;
      end else if (p == 4) begin
         if (b != RECORD_VERSION && herr == HE_NONE) herr = HE_VERSION;
      end else if (p < 8) begin
         if (b != 8'd0 && herr == HE_NONE) herr = HE_VERSION;
      end else if (p < 16) begin
         gen_acc = {gen_acc[55:0], b};
      end else if (p < HEADER_BYTES) begin
         len_acc = {len_acc[23:0], b};
      end
      len = len_acc;

      if (p < HEADER_BYTES) begin
         crc_run = crc32_update(crc_run, b);
      end else if (len <= LEN_MAX) begin
         if (p < HEADER_BYTES + len) crc_run = crc32_update(crc_run, b);
         else if (p < HEADER_BYTES + len + TRAILER_BYTES) trailer_acc = {trailer_acc[23:0], b};
      end
      // CRC is sealed on the last payload byte (or last header byte for an empty payload)
      if (p >= HEADER_BYTES - 1 && len <= LEN_MAX && p == HEADER_BYTES - 1 + len)
         crc_seal = ~crc_run;

      if (frame_pos < MAX_RECORD_BYTES) frame_pos++;

      if (l) begin
         rlen = frame_pos;
         if (rlen < HEADER_BYTES + TRAILER_BYTES) r.status = ST_SHORT;
         else if (herr == HE_MAGIC) r.status = ST_MAGIC;
         else if (herr != HE_NONE) r.status = ST_VERSION;
         else if (len > LEN_MAX || len > rlen - HEADER_BYTES - TRAILER_BYTES)
            r.status = ST_OVERRUN;
         else if (trailer_acc != crc_seal) r.status = ST_CRC;
         else r.status = ST_OK;
         r.generation = (r.status inside {ST_SHORT, ST_MAGIC, ST_VERSION}) ? 64'd0 : gen_acc;
         r.payload_length = (r.status == ST_OK) ? len_acc[11:0] : 12'd0;
         pending_checks.push_back(r);
         clear_frame();
      end
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h, expected %0h (byte %0d)", what, got, want, bytes_sent);
      error_count++;
   endtask

   task automatic check_response();
      record_check_type want;
      if (pending_checks.size() == 0) begin
         report_mismatch("unexpected response, status", rsp_bus.record_status, 0);
      end else begin
         want = pending_checks.pop_front();
         if (rsp_bus.record_status !== want.status)
            report_mismatch("record_status", rsp_bus.record_status, want.status);
         if (rsp_bus.generation !== want.generation)
            report_mismatch("generation", rsp_bus.generation, want.generation);
         if (rsp_bus.payload_length !== want.payload_length)
            report_mismatch("payload_length", rsp_bus.payload_length, want.payload_length);
      end
   endtask

   // sample both channels and the register port at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         magic_model = '0;
         clear_frame();
         pending_checks.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr == MAGIC_ADDR)
            magic_model = csr_pwdata;
         if (rsp_bus.valid && rsp_bus.ready) check_response();
         if (req_bus.valid && req_bus.ready) predict_byte(req_bus.data_byte, req_bus.last_byte);
      end
   end

   // response backpressure: short stalls mostly, some long ones, some long ready stretches
   always @(negedge clock) begin
      if (ready_hold != 0) begin
         ready_hold--;
      end else begin
         ready_sel = $urandom_range(0, 99);
         if (ready_sel < 55) begin
            rsp_bus.ready <= 1'b1;
            ready_hold = $urandom_range(0, 6);
         end else if (ready_sel < 70) begin
            rsp_bus.ready <= 1'b1;
            ready_hold = $urandom_range(20, 80);
         end else if (ready_sel < 95) begin
            rsp_bus.ready <= 1'b0;
            ready_hold = $urandom_range(0, 3);
         end else begin
            rsp_bus.ready <= 1'b0;
            ready_hold = $urandom_range(15, 50);
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb_crc32_record_frame_validator_core: errors");
      $finish;
   end

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (steady_send) return 0;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // called and returns at a falling edge; valid stays high across back-to-back requests
   task automatic send_byte(input logic [7:0] b, input logic l);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.data_byte <= b;
      req_bus.last_byte <= l;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      @(negedge clock);
   endtask

   task automatic send_frame(input int unsigned n);
      for (int unsigned i = 0; i < n; i++) send_byte(frame_buf[i], i == n - 1);
      bytes_sent += n;
   endtask

   task automatic build_frame(input logic [31:0] magic, input logic [7:0] version,
                              input logic [23:0] rsvd, input logic [63:0] gen,
                              input logic [31:0] len_field, input int unsigned payload_n,
                              input int unsigned extra_n);
      logic [31:0] crc;
      frame_buf.delete();
      for (int i = 3; i >= 0; i--) frame_buf.push_back(magic[8*i +: 8]);
      frame_buf.push_back(version);
      for (int i = 2; i >= 0; i--) frame_buf.push_back(rsvd[8*i +: 8]);
      for (int i = 7; i >= 0; i--) frame_buf.push_back(gen[8*i +: 8]);
      for (int i = 3; i >= 0; i--) frame_buf.push_back(len_field[8*i +: 8]);
      repeat (payload_n) frame_buf.push_back(8'($urandom));
      crc = 32'hFFFFFFFF;
      foreach (frame_buf[i]) crc = crc32_update(crc, frame_buf[i]);
      crc = ~crc;
      for (int i = 3; i >= 0; i--) frame_buf.push_back(crc[8*i +: 8]);
      repeat (extra_n) frame_buf.push_back(8'($urandom));
   endtask

   task automatic send_good(input logic [63:0] gen, input int unsigned plen,
                            input int unsigned extra_n);
      build_frame(cur_magic, RECORD_VERSION, 24'd0, gen, plen, plen, extra_n);
      send_frame(frame_buf.size());
   endtask

   // stop requests and wait for every outstanding record result
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_checks.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] a, input logic [31:0] d);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= a;
      csr_pwdata  <= d;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
   endtask

   task automatic csr_read_check(input logic [CSR_ADDR_W-1:0] a, input logic [31:0] want);
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= a;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      @(negedge clock);
      if (got !== want) report_mismatch("magic_word readback", got, want);
   endtask

   task automatic set_magic(input logic [31:0] value);
      drain_results();
      csr_write(MAGIC_ADDR, value);
      csr_read_check(MAGIC_ADDR, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      cur_magic = value;
   endtask

   function automatic int unsigned pick_payload_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(0, 12);
      if (r < 95) return $urandom_range(13, 48);
      return $urandom_range(49, 160);
   endfunction

   task automatic test_reset_magic();
      csr_read_check(MAGIC_ADDR, 32'd0);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      // magic of zero after reset, empty payload
      send_good(64'h0123_4567_89AB_CDEF, 0, 0);
   endtask

   task automatic test_directed();
      steady_send = 1'b0;
      set_magic(32'hFFFF_FFFF);
      send_good(64'hFFFF_FFFF_FFFF_FFFF, 0, 3);
      send_good(64'd0, 5, 0);
      // short: lone bytes flagged last, and one byte short of a minimal record
      frame_buf.delete();
      frame_buf.push_back(8'h00);
      send_frame(1);
      frame_buf[0] = 8'hFF;
      send_frame(1);
      build_frame(cur_magic, RECORD_VERSION, 24'd0, 64'd7, 0, 0, 0);
      send_frame(23);
      // magic outranks version
      build_frame(cur_magic ^ 32'h1, 8'd2, 24'd0, 64'd9, 0, 0, 0);
      send_frame(frame_buf.size());
      build_frame(cur_magic, 8'd0, 24'd0, 64'd9, 2, 2, 0);
      send_frame(frame_buf.size());
      build_frame(cur_magic, RECORD_VERSION, 24'h00_80_00, 64'd9, 2, 2, 0);
      send_frame(frame_buf.size());
      // declared length one past what the record holds
      build_frame(cur_magic, RECORD_VERSION, 24'd0, 64'd11, 4, 3, 0);
      send_frame(frame_buf.size());
      // oversized declared lengths
      build_frame(cur_magic, RECORD_VERSION, 24'd0, 64'd12, 32'hFFFF_FFFF, 2, 0);
      send_frame(frame_buf.size());
      build_frame(cur_magic, RECORD_VERSION, 24'd0, 64'd13, LEN_MAX + 1, 2, 0);
      send_frame(frame_buf.size());
      // trailer bit flipped
      build_frame(cur_magic, RECORD_VERSION, 24'd0, 64'd14, 6, 6, 0);
      frame_buf[frame_buf.size() - 1] ^= 8'h01;
      send_frame(frame_buf.size());
      // declared length shorter than the payload
      build_frame(cur_magic, RECORD_VERSION, 24'd0, 64'd15, 2, 4, 0);
      send_frame(frame_buf.size());
   endtask

   task automatic test_random_records(input int unsigned byte_budget, input logic pause_once);
      int unsigned start;
      int unsigned kind;
      int unsigned plen;
      int unsigned extra_n;
      int unsigned n;
      int unsigned pos;
      logic [63:0] gen;
      logic [31:0] lf;
      logic [31:0] m;
      logic [7:0]  ver;
      logic [23:0] rsvd;
      logic        paused;
      start  = bytes_sent;
      paused = 1'b0;
      while (bytes_sent - start < byte_budget) begin
         steady_send = ($urandom_range(0, 3) == 0);
         kind    = $urandom_range(0, 99);
         plen    = pick_payload_len();
         gen     = {$urandom, $urandom};
         extra_n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
         n       = 0;
         if (kind < 62) begin
            build_frame(cur_magic, RECORD_VERSION, 24'd0, gen, plen, plen, extra_n);
         end else if (kind < 72) begin
            build_frame(cur_magic, RECORD_VERSION, 24'd0, gen, plen, plen, extra_n);
            pos = $urandom_range(0, frame_buf.size() - 1);
            frame_buf[pos] ^= 8'(1 << $urandom_range(0, 7));
         end else if (kind < 79) begin
            build_frame(cur_magic, RECORD_VERSION, 24'd0, gen, plen, plen, extra_n);
            n = $urandom_range(1, frame_buf.size() - 1);
         end else if (kind < 85) begin
            if (plen > 0 && $urandom_range(0, 1) == 1)
               lf = plen - $urandom_range(1, (plen < 8) ? plen : 8);
            else
               lf = plen + $urandom_range(1, 8);
            build_frame(cur_magic, RECORD_VERSION, 24'd0, gen, lf, plen, extra_n);
         end else if (kind < 90) begin
            frame_buf.delete();
            repeat ($urandom_range(1, 40)) frame_buf.push_back(8'($urandom));
         end else if (kind < 94) begin
            lf = $urandom_range(LEN_MAX + 1, 32'hFFFF_FFFF);
            build_frame(cur_magic, RECORD_VERSION, 24'd0, gen, lf, plen, extra_n);
         end else begin
            ver  = ($urandom_range(0, 3) == 0) ? RECORD_VERSION : 8'($urandom);
            rsvd = ($urandom_range(0, 1) == 1) ? 24'(1 << $urandom_range(0, 23)) : 24'd0;
            m    = ($urandom_range(0, 2) == 0) ? cur_magic ^ (32'd1 << $urandom_range(0, 31))
                                               : cur_magic;
            build_frame(m, ver, rsvd, gen, plen, plen, extra_n);
         end
         if (n == 0) n = frame_buf.size();
         send_frame(n);
         // hold off new requests once until every result is back
         if (pause_once && !paused && bytes_sent - start >= byte_budget / 2) begin
            drain_results();
            paused = 1'b1;
         end
      end
   endtask

   task automatic test_longest_record();
      steady_send = 1'b0;
      drain_results();
      // long payload, then bytes past the trailer
      send_good({$urandom, $urandom}, 512, 4);
   endtask

   initial begin
      reset             = 1'b1;
      csr_psel          = 1'b0;
      csr_penable       = 1'b0;
      csr_pwrite        = 1'b0;
      csr_paddr         = '0;
      csr_pwdata        = '0;
      req_bus.valid     = 1'b0;
      req_bus.data_byte = '0;
      req_bus.last_byte = 1'b0;
      rsp_bus.ready     = 1'b0;
      ready_hold        = 0;
      error_count       = 0;
      bytes_sent        = 0;
      steady_send       = 1'b0;
      cur_magic         = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_reset_magic();
      test_directed();
      set_magic($urandom);
      test_random_records(650, 1'b1);
      set_magic(32'd0);
      test_random_records(330, 1'b0);
      test_longest_record();

      drain_results();
      repeat (8) @(negedge clock);
      if (error_count == 0)
         $display("tb_crc32_record_frame_validator_core: clean");
      else
         $display("tb_crc32_record_frame_validator_core: errors");
      $finish;
   end

endmodule
